FILE: rtl/core/wgps_pkg.sv
package wgps_pkg;

   // Fixed field widths
   localparam int unsigned INDEX_BITS  = 7;   // col / row fields, signed
   localparam int unsigned CFG_BITS    = 6;   // grid_columns / grid_rows
   localparam int unsigned NEAREST_W   = 10;  // nearest_index field
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   // Action codes
   localparam logic [1:0] ACT_WRITE   = 2'd0;
   localparam logic [1:0] ACT_NEAREST = 2'd1;
   localparam logic [1:0] ACT_READ    = 2'd2;

   // Status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_SAT   = 2'd2;

   // Register indexes
   localparam logic REG_GRID_COLUMNS = 1'b0;
   localparam logic REG_GRID_ROWS    = 1'b1;

   // Reset grid size and smallest legal grid size
   localparam logic [CFG_BITS-1:0] GRID_RESET = 6'd4;
   localparam logic [CFG_BITS-1:0] GRID_MIN   = 6'd2;

endpackage

FILE: rtl/core/wgps_ram.sv
module wgps_ram #(
   parameter int unsigned WIDTH = 36,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/warp_grid_point_store.sv
// Warp grid point store. Holds a row-major grid of (x, y) control points in
// one single-port-read memory of MAX_COLUMNS*MAX_ROWS entries and serves one
// request at a time. A write passes through decode and finish before its
// result is registered. An extrapolated read fetches four grid points, one
// per cycle, and sums up to four of them with weights. A nearest query
// streams every point in use through a distance pipeline of difference,
// square, sum and compare at one memory read per cycle. The next request
// can be taken in the cycle after the result is registered. A result that
// still waits in the response register holds the block until it is taken.
// Entries must be written before a read or a query touches them. Grid size
// registers sit at byte 0 (columns) and byte 4 (rows). Values whose low six
// bits fall outside 2 to the maximum are ignored, and a resize leaves stored points in place.
module warp_grid_point_store
   import wgps_pkg::*;
#(
   parameter int unsigned MAX_COLUMNS = 32,
   parameter int unsigned MAX_ROWS    = 32,
   parameter int unsigned COORD_BITS  = 18
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_action,
   input  logic signed [INDEX_BITS-1:0]  req_col,
   input  logic signed [INDEX_BITS-1:0]  req_row,
   input  logic signed [COORD_BITS-1:0]  req_point_x,
   input  logic signed [COORD_BITS-1:0]  req_point_y,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_BITS-1:0]  rsp_result_x,
   output logic signed [COORD_BITS-1:0]  rsp_result_y,
   output logic [NEAREST_W-1:0]          rsp_nearest_index,
   output logic [1:0]                    rsp_status,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_W-1:0]         paddr,
   input  logic [CSR_DATA_W-1:0]         pwdata,
   output logic [CSR_DATA_W-1:0]         prdata,
   output logic                          pready
);

   localparam int unsigned DEPTH  = MAX_COLUMNS * MAX_ROWS;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned COL_W  = $clog2(MAX_COLUMNS);
   localparam int unsigned ROW_W  = $clog2(MAX_ROWS);
   localparam int unsigned MUL_W  = ADDR_W + 8;
   localparam int unsigned DIFF_W = COORD_BITS + 1;
   localparam int unsigned SQ_W   = 2 * DIFF_W;
   localparam int unsigned DIST_W = SQ_W + 1;
   localparam int unsigned ACC_W  = COORD_BITS + 4;
   localparam int unsigned AXIS_W = 9;
   localparam int unsigned WIDE_W = ADDR_W + NEAREST_W;

   // point fetch order for an extrapolated read: column part, row part
   localparam logic [1:0] PT_EE = 2'd0;
   localparam logic [1:0] PT_ER = 2'd1;
   localparam logic [1:0] PT_RE = 2'd2;
   localparam logic [1:0] PT_RR = 2'd3;

   localparam logic signed [ACC_W-1:0] ACC_MAX =
      {{(ACC_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN =
      {{(ACC_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_READ,
      ST_FINISH
   } state_type;

   state_type state_ff;

   // ---------------------------------------------------------------
   // Grid size registers
   logic [CFG_BITS-1:0] cols_ff, rows_ff;
   logic [CFG_BITS-1:0] csr_val;
   logic                csr_wr;

   assign csr_val = pwdata[CFG_BITS-1:0];
   assign csr_wr  = psel && penable && pwrite && pready;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= GRID_RESET;
         rows_ff <= GRID_RESET;
      end else if (csr_wr && csr_val >= GRID_MIN) begin
         if (paddr[2] == REG_GRID_COLUMNS && 32'(csr_val) <= MAX_COLUMNS) begin
            cols_ff <= csr_val;
         end
         if (paddr[2] == REG_GRID_ROWS && 32'(csr_val) <= MAX_ROWS) begin
            rows_ff <= csr_val;
         end
      end
   end

   assign prdata = (paddr[2] == REG_GRID_ROWS) ?
                   {{(CSR_DATA_W-CFG_BITS){1'b0}}, rows_ff} :
                   {{(CSR_DATA_W-CFG_BITS){1'b0}}, cols_ff};

   // ---------------------------------------------------------------
   // Request beat capture
   logic [1:0]                   act_ff;
   logic signed [INDEX_BITS-1:0] col_ff, row_ff;
   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic                         req_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff <= req_action;
         col_ff <= req_col;
         row_ff <= req_row;
         px_ff  <= req_point_x;
         py_ff  <= req_point_y;
      end
   end

   // ---------------------------------------------------------------
   // Index decode: range checks and edge / mirror split per axis
   logic signed [AXIS_W-1:0] col9, row9, maxc9, maxr9;
   logic signed [AXIS_W-1:0] col_edge9, col_refl9, row_edge9, row_refl9;
   logic                     col_lo, col_hi, row_lo, row_hi;
   logic                     wr_bad, rd_bad;

   assign col9  = AXIS_W'(col_ff);
   assign row9  = AXIS_W'(row_ff);
   assign maxc9 = $signed({3'b000, cols_ff}) - 9'sd1;
   assign maxr9 = $signed({3'b000, rows_ff}) - 9'sd1;

   assign col_lo = col9 < 0;
   assign col_hi = col9 > maxc9;
   assign row_lo = row9 < 0;
   assign row_hi = row9 > maxr9;

   assign wr_bad = col_lo || col_hi || row_lo || row_hi;
   assign rd_bad = (col9 < -maxc9) || (col9 > (maxc9 <<< 1)) ||
                   (row9 < -maxr9) || (row9 > (maxr9 <<< 1));

   assign col_edge9 = col_lo ? '0 : (col_hi ? maxc9 : col9);
   assign col_refl9 = col_lo ? -col9 : (col_hi ? (maxc9 <<< 1) - col9 : col9);
   assign row_edge9 = row_lo ? '0 : (row_hi ? maxr9 : row9);
   assign row_refl9 = row_lo ? -row9 : (row_hi ? (maxr9 <<< 1) - row9 : row9);

   logic [COL_W-1:0] col_edge_ff, col_refl_ff;
   logic [ROW_W-1:0] row_edge_ff, row_refl_ff;
   logic             xo_ff, yo_ff, range_err_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_DECODE) begin
         col_edge_ff  <= col_edge9[COL_W-1:0];
         col_refl_ff  <= col_refl9[COL_W-1:0];
         row_edge_ff  <= row_edge9[ROW_W-1:0];
         row_refl_ff  <= row_refl9[ROW_W-1:0];
         xo_ff        <= col_lo || col_hi;
         yo_ff        <= row_lo || row_hi;
         range_err_ff <= (act_ff == ACT_WRITE) ? wr_bad :
                         (act_ff == ACT_READ)  ? rd_bad :
                         (act_ff != ACT_NEAREST);
      end
   end

   // ---------------------------------------------------------------
   // Row-major address: row * grid_columns + col
   logic [1:0]        rd_step_ff;
   logic [COL_W-1:0]  addr_col;
   logic [ROW_W-1:0]  addr_row;
   logic [MUL_W-1:0]  addr_wide, count_wide;
   logic [ADDR_W-1:0] grid_addr, scan_last;

   always_comb begin
      if (state_ff == ST_READ) begin
         addr_col = rd_step_ff[1] ? col_refl_ff : col_edge_ff;
         addr_row = rd_step_ff[0] ? row_refl_ff : row_edge_ff;
      end else begin
         addr_col = col9[COL_W-1:0];
         addr_row = row9[ROW_W-1:0];
      end
   end

   assign addr_wide  = MUL_W'(addr_row) * MUL_W'(cols_ff) + MUL_W'(addr_col);
   assign grid_addr  = addr_wide[ADDR_W-1:0];
   assign count_wide = MUL_W'(cols_ff) * MUL_W'(rows_ff) - MUL_W'(1);
   assign scan_last  = count_wide[ADDR_W-1:0];

   // ---------------------------------------------------------------
   // Point memory
   logic                         ram_we;
   logic [ADDR_W-1:0]            ram_raddr;
   logic [2*COORD_BITS-1:0]      ram_rdata;
   logic [ADDR_W-1:0]            scan_addr_ff, scan_last_ff;
   logic signed [COORD_BITS-1:0] mem_x, mem_y;

   assign ram_we    = (state_ff == ST_DECODE) && (act_ff == ACT_WRITE) && !wr_bad;
   assign ram_raddr = (state_ff == ST_SCAN) ? scan_addr_ff : grid_addr;
   assign mem_x     = ram_rdata[2*COORD_BITS-1:COORD_BITS];
   assign mem_y     = ram_rdata[COORD_BITS-1:0];

   wgps_ram #(
      .WIDTH (2 * COORD_BITS),
      .DEPTH (DEPTH)
   ) u_point_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (grid_addr),
      .wr_data ({px_ff, py_ff}),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------
   // Control: sequencer, read issue, response register
   logic              issuing_ff;
   logic              rd_vld_ff;
   logic [ADDR_W-1:0] rd_idx_ff;
   logic [1:0]        rd_lat_ff;
   logic              diff_vld_ff, sq_vld_ff;
   logic              rsp_valid_ff;
   logic              rsp_free;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;
   logic [NEAREST_W-1:0]         rsp_idx_ff;
   logic [1:0]                   rsp_status_ff;
   logic signed [COORD_BITS-1:0] fin_x, fin_y;
   logic [NEAREST_W-1:0]         fin_idx;
   logic [1:0]                   fin_status;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issuing_ff   <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= issuing_ff && (state_ff == ST_SCAN || state_ff == ST_READ);
         rd_idx_ff <= scan_addr_ff;
         rd_lat_ff <= rd_step_ff;
         // response valid: load a new beat, else drop the one taken
         if (state_ff == ST_FINISH && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               scan_addr_ff <= '0;
               scan_last_ff <= scan_last;
               rd_step_ff   <= PT_EE;
               if (act_ff == ACT_NEAREST) begin
                  issuing_ff <= 1'b1;
                  state_ff   <= ST_SCAN;
               end else if (act_ff == ACT_READ && !rd_bad) begin
                  issuing_ff <= 1'b1;
                  state_ff   <= ST_READ;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_SCAN: begin
               if (issuing_ff) begin
                  scan_addr_ff <= scan_addr_ff + 1'b1;
                  if (scan_addr_ff == scan_last_ff) begin
                     issuing_ff <= 1'b0;
                  end
               end else if (!rd_vld_ff && !diff_vld_ff && !sq_vld_ff) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_READ: begin
               if (issuing_ff) begin
                  rd_step_ff <= rd_step_ff + 1'b1;
                  if (rd_step_ff == PT_RR) begin
                     issuing_ff <= 1'b0;
                  end
               end
               if (rd_vld_ff && rd_lat_ff == PT_RR) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  rsp_x_ff      <= fin_x;
                  rsp_y_ff      <= fin_y;
                  rsp_idx_ff    <= fin_idx;
                  rsp_status_ff <= fin_status;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Nearest scan pipeline: difference, square, sum and compare
   logic signed [DIFF_W-1:0]     dx_ff, dy_ff;
   logic signed [COORD_BITS-1:0] diff_x_ff, diff_y_ff, sq_x_ff, sq_y_ff;
   logic [ADDR_W-1:0]            diff_idx_ff, sq_idx_ff;
   logic signed [SQ_W-1:0]       sqx_s, sqy_s;
   logic [SQ_W-1:0]              sqx_ff, sqy_ff;
   logic [DIST_W-1:0]            dist_sum, best_d_ff;
   logic signed [COORD_BITS-1:0] best_x_ff, best_y_ff;
   logic [ADDR_W-1:0]            best_idx_ff;
   logic                         best_vld_ff;
   logic                         scan_rd;

   assign scan_rd  = rd_vld_ff && (state_ff == ST_SCAN);
   assign sqx_s    = dx_ff * dx_ff;
   assign sqy_s    = dy_ff * dy_ff;
   assign dist_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_vld_ff <= 1'b0;
         sq_vld_ff   <= 1'b0;
         best_vld_ff <= 1'b0;
      end else begin
         diff_vld_ff <= scan_rd;
         sq_vld_ff   <= diff_vld_ff;
         if (state_ff == ST_DECODE) begin
            best_vld_ff <= 1'b0;
         end else if (sq_vld_ff) begin
            best_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      // stage 1: differences against the query point
      dx_ff       <= DIFF_W'(px_ff) - DIFF_W'(mem_x);
      dy_ff       <= DIFF_W'(py_ff) - DIFF_W'(mem_y);
      diff_x_ff   <= mem_x;
      diff_y_ff   <= mem_y;
      diff_idx_ff <= rd_idx_ff;
      // stage 2: squares
      sqx_ff      <= $unsigned(sqx_s);
      sqy_ff      <= $unsigned(sqy_s);
      sq_x_ff     <= diff_x_ff;
      sq_y_ff     <= diff_y_ff;
      sq_idx_ff   <= diff_idx_ff;
      // stage 3: keep the first strictly smaller distance
      if (sq_vld_ff && (!best_vld_ff || dist_sum < best_d_ff)) begin
         best_d_ff   <= dist_sum;
         best_x_ff   <= sq_x_ff;
         best_y_ff   <= sq_y_ff;
         best_idx_ff <= sq_idx_ff;
      end
   end

   // ---------------------------------------------------------------
   // Extrapolated read: weighted sum of up to four grid points
   //   both axes out: 4*EE - 2*ER - 2*RE + RR
   logic signed [ACC_W-1:0] acc_x_ff, acc_y_ff;
   logic signed [ACC_W-1:0] term_x, term_y, ext_x, ext_y;
   logic                    w_en, w_neg;
   logic [1:0]              w_sh;

   always_comb begin
      case (rd_lat_ff)
         PT_EE: begin
            w_en  = 1'b1;
            w_neg = 1'b0;
            w_sh  = {1'b0, xo_ff} + {1'b0, yo_ff};
         end
         PT_ER: begin
            w_en  = yo_ff;
            w_neg = 1'b1;
            w_sh  = {1'b0, xo_ff};
         end
         PT_RE: begin
            w_en  = xo_ff;
            w_neg = 1'b1;
            w_sh  = {1'b0, yo_ff};
         end
         default: begin
            w_en  = xo_ff && yo_ff;
            w_neg = 1'b0;
            w_sh  = 2'd0;
         end
      endcase
      ext_x  = ACC_W'(mem_x) <<< w_sh;
      ext_y  = ACC_W'(mem_y) <<< w_sh;
      term_x = !w_en ? '0 : (w_neg ? -ext_x : ext_x);
      term_y = !w_en ? '0 : (w_neg ? -ext_y : ext_y);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DECODE) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
      end else if (rd_vld_ff && state_ff == ST_READ) begin
         acc_x_ff <= acc_x_ff + term_x;
         acc_y_ff <= acc_y_ff + term_y;
      end
   end

   // ---------------------------------------------------------------
   // Result selection with saturation
   logic                    hi_x, lo_x, hi_y, lo_y;
   logic [COORD_BITS-1:0]   clip_x, clip_y;
   logic [WIDE_W-1:0]       best_idx_wide;

   assign hi_x = acc_x_ff > ACC_MAX;
   assign lo_x = acc_x_ff < ACC_MIN;
   assign hi_y = acc_y_ff > ACC_MAX;
   assign lo_y = acc_y_ff < ACC_MIN;
   assign clip_x = hi_x ? ACC_MAX[COORD_BITS-1:0] :
                   (lo_x ? ACC_MIN[COORD_BITS-1:0] : acc_x_ff[COORD_BITS-1:0]);
   assign clip_y = hi_y ? ACC_MAX[COORD_BITS-1:0] :
                   (lo_y ? ACC_MIN[COORD_BITS-1:0] : acc_y_ff[COORD_BITS-1:0]);
   assign best_idx_wide = {{NEAREST_W{1'b0}}, best_idx_ff};

   always_comb begin
      fin_x      = '0;
      fin_y      = '0;
      fin_idx    = '0;
      fin_status = range_err_ff ? STAT_RANGE : STAT_OK;
      if (!range_err_ff) begin
         case (act_ff)
            ACT_NEAREST: begin
               fin_x   = best_x_ff;
               fin_y   = best_y_ff;
               fin_idx = best_idx_wide[NEAREST_W-1:0];
            end
            ACT_READ: begin
               fin_x = $signed(clip_x);
               fin_y = $signed(clip_y);
               if (hi_x || lo_x || hi_y || lo_y) begin
                  fin_status = STAT_SAT;
               end
            end
            default: begin
               fin_x = '0;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_x      = rsp_x_ff;
   assign rsp_result_y      = rsp_y_ff;
   assign rsp_nearest_index = rsp_idx_ff;
   assign rsp_status        = rsp_status_ff;

   // ---------------------------------------------------------------
   // Assertions
   a_accept_decodes : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_DECODE)
      else $error("accepted beat did not enter decode");

   a_no_write_in_scan : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_READ) |-> !ram_we)
      else $error("point memory written during a scan or read");

   a_grid_in_range : assert property (@(posedge clock) disable iff (reset)
      (cols_ff >= GRID_MIN) && (32'(cols_ff) <= MAX_COLUMNS) &&
      (rows_ff >= GRID_MIN) && (32'(rows_ff) <= MAX_ROWS))
      else $error("grid size register out of range");

   a_finish_holds : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && rsp_valid_ff && !rsp_ready |=> state_ff == ST_FINISH)
      else $error("result dropped while response register was full");

endmodule

FILE: tb/warp_grid_point_store_test.sv
`timescale 1ns / 100ps

module warp_grid_point_store_test;
   import wgps_pkg::*;

   localparam int MAX_COLUMNS  = 32;
   localparam int MAX_ROWS     = 32;
   localparam int COORD_BITS   = 18;
   localparam int STORE_DEPTH  = MAX_COLUMNS * MAX_ROWS;
   localparam int ITEM_TARGET  = 580;
   localparam int IDLE_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [1:0] ACT_UNDEFINED = 2'd3;

   localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
   localparam longint COORD_MIN = -COORD_MAX - 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [INDEX_BITS-1:0] grid_index_type;

   localparam coord_type COORD_TOP    = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_BOTTOM = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef struct {
      logic [1:0]     action;
      grid_index_type col;
      grid_index_type row;
      coord_type      x;
      coord_type      y;
   } point_request_type;

   typedef struct {
      coord_type            x;
      coord_type            y;
      logic [NEAREST_W-1:0] index;
      logic [1:0]           status;
   } point_result_type;

   // DUT connections
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   wire                   req_ready;
   logic [1:0]            req_action = ACT_WRITE;
   grid_index_type        req_col = '0;
   grid_index_type        req_row = '0;
   coord_type             req_point_x = '0;
   coord_type             req_point_y = '0;
   wire                   rsp_valid;
   logic                  rsp_ready = 1'b0;
   wire signed [COORD_BITS-1:0] rsp_result_x;
   wire signed [COORD_BITS-1:0] rsp_result_y;
   wire [NEAREST_W-1:0]   rsp_nearest_index;
   wire [1:0]             rsp_status;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   wire [CSR_DATA_W-1:0]  prdata;
   wire                   pready;

   // Shadow copy of the point grid and its size
   longint grid_x [STORE_DEPTH];
   longint grid_y [STORE_DEPTH];
   int     grid_cols = GRID_RESET;
   int     grid_rows = GRID_RESET;
   // entries that the queued stimulus has already written
   bit     loaded [STORE_DEPTH];

   point_request_type requests_pending [$];
   point_result_type  results_due [$];

   int mismatches   = 0;
   int idle_cycles  = 0;
   int items_queued = 0;
   bit req_taken    = 1'b0;
   int req_gap      = 0;
   int req_calm     = 0;
   int rsp_stall    = 0;
   int rsp_calm     = 0;

   warp_grid_point_store #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .COORD_BITS  (COORD_BITS)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_col           (req_col),
      .req_row           (req_row),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_x      (rsp_result_x),
      .rsp_result_y      (rsp_result_y),
      .rsp_nearest_index (rsp_nearest_index),
      .rsp_status        (rsp_status),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Grid predictor
   // ---------------------------------------------------------------

   function automatic void fetch_point(input int c, input int r,
                                       output longint x, output longint y);
      int k;
      k = (r * grid_cols + c) % STORE_DEPTH;
      x = grid_x[k];
      y = grid_y[k];
   endfunction

   // Splits one axis into edge and mirrored index; true when beyond the grid
   function automatic bit mirror_axis(input int v, input int maxv,
                                      output int edge_pos, output int refl);
      if (v < 0) begin
         edge_pos = 0;
         refl = -v;
         return 1'b1;
      end
      if (v > maxv) begin
         edge_pos = maxv;
         refl = 2 * maxv - v;
         return 1'b1;
      end
      edge_pos = v;
      refl = v;
      return 1'b0;
   endfunction

   function automatic longint clip_coord(input longint v, inout bit clipped);
      if (v > COORD_MAX) begin
         clipped = 1'b1;
         return COORD_MAX;
      end
      if (v < COORD_MIN) begin
         clipped = 1'b1;
         return COORD_MIN;
      end
      return v;
   endfunction

   function automatic point_result_type predict_point_result(input point_request_type req);
      point_result_type res;
      int col, row, maxc, maxr, k, n, i, ce, cr, re, rr;
      longint ax, ay, bx, by, cx, cy, dx, dy, sq_dist, best;
      bit xo, yo, clipped;
      col = int'(req.col);
      row = int'(req.row);
      maxc = grid_cols - 1;
      maxr = grid_rows - 1;
      res.x = '0;
      res.y = '0;
      res.index = '0;
      res.status = STAT_OK;
      case (req.action)
         ACT_WRITE: begin
            if (col < 0 || row < 0 || col > maxc || row > maxr) begin
               res.status = STAT_RANGE;
            end else begin
               k = (row * grid_cols + col) % STORE_DEPTH;
               grid_x[k] = longint'(req.x);
               grid_y[k] = longint'(req.y);
            end
         end
         ACT_NEAREST: begin
            // first point wins on a tie, so only a strictly closer one replaces it
            n = grid_cols * grid_rows;
            best = 0;
            for (i = 0; i < n && i < STORE_DEPTH; i++) begin
               dx = longint'(req.x) - grid_x[i];
               dy = longint'(req.y) - grid_y[i];
               sq_dist = dx * dx + dy * dy;
               if (i == 0 || sq_dist < best) begin
                  best = sq_dist;
                  res.index = NEAREST_W'(i);
                  res.x = coord_type'(grid_x[i]);
                  res.y = coord_type'(grid_y[i]);
               end
            end
         end
         ACT_READ: begin
            if (col < -maxc || col > 2 * maxc || row < -maxr || row > 2 * maxr) begin
               res.status = STAT_RANGE;
            end else begin
               xo = mirror_axis(col, maxc, ce, cr);
               yo = mirror_axis(row, maxr, re, rr);
               // extrapolate along rows first, then along columns
               fetch_point(ce, re, ax, ay);
               if (yo) begin
                  fetch_point(ce, rr, bx, by);
                  ax = 2 * ax - bx;
                  ay = 2 * ay - by;
               end
               if (xo) begin
                  fetch_point(cr, re, cx, cy);
                  if (yo) begin
                     fetch_point(cr, rr, bx, by);
                     cx = 2 * cx - bx;
                     cy = 2 * cy - by;
                  end
                  ax = 2 * ax - cx;
                  ay = 2 * ay - cy;
               end
               clipped = 1'b0;
               ax = clip_coord(ax, clipped);
               ay = clip_coord(ay, clipped);
               res.x = coord_type'(ax);
               res.y = coord_type'(ay);
               if (clipped) begin
                  res.status = STAT_SAT;
               end
            end
         end
         default: begin
            res.status = STAT_RANGE;
         end
      endcase
      return res;
   endfunction

   function automatic void check_field(input string name,
                                       input logic signed [COORD_BITS-1:0] due,
                                       input logic signed [COORD_BITS-1:0] got);
      if (got !== due) begin
         mismatches++;
         $display("%0t: %s expected %0d, got %0d", $time, name, due, got);
      end
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------

   // Mostly zero, sometimes short, rarely long; occasional stretch of none
   function automatic int pick_gap(inout int calm);
      int pick;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // coarse values sit on a few lattice spots, so nearest ties are common
   function automatic coord_type rand_coord(input bit coarse);
      int pick;
      if (coarse) return coord_type'(int'($urandom_range(0, 4)) * 2048 - 4096);
      pick = $urandom_range(0, 99);
      if (pick < 4) return COORD_TOP;
      if (pick < 8) return COORD_BOTTOM;
      if (pick < 12) return coord_type'(int'($urandom_range(0, 2)) - 1);
      if (pick < 55) return coord_type'($urandom());
      return coord_type'(int'($urandom_range(0, 8191)) - 4096);
   endfunction

   function automatic grid_index_type rand_index();
      return grid_index_type'($urandom());
   endfunction

   task automatic queue_request(input logic [1:0] act, input int col, input int row,
                                input coord_type x, input coord_type y);
      point_request_type req;
      req.action = act;
      req.col = grid_index_type'(col);
      req.row = grid_index_type'(row);
      req.x = x;
      req.y = y;
      requests_pending.push_back(req);
      items_queued++;
      if (act == ACT_WRITE && col >= 0 && row >= 0 && col < grid_cols && row < grid_rows) begin
         loaded[(row * grid_cols + col) % STORE_DEPTH] = 1'b1;
      end
   endtask

   task automatic queue_random_request(input bit coarse);
      int pick, maxc, maxr, col, row;
      maxc = grid_cols - 1;
      maxr = grid_rows - 1;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         if ($urandom_range(0, 9) < 8) begin
            col = $urandom_range(0, maxc);
            row = $urandom_range(0, maxr);
         end else begin
            col = rand_index();
            row = rand_index();
         end
         queue_request(ACT_WRITE, col, row, rand_coord(coarse), rand_coord(coarse));
      end else if (pick < 58) begin
         queue_request(ACT_NEAREST, rand_index(), rand_index(),
                       rand_coord(coarse), rand_coord(coarse));
      end else if (pick < 95) begin
         pick = $urandom_range(0, 9);
         col = int'($urandom_range(0, 3 * maxc)) - maxc;
         row = int'($urandom_range(0, 3 * maxr)) - maxr;
         if (pick == 8) begin
            // one step past the extrapolation window
            if ($urandom_range(0, 1)) begin
               col = $urandom_range(0, 1) ? -grid_cols : 2 * maxc + 1;
            end else begin
               row = $urandom_range(0, 1) ? -grid_rows : 2 * maxr + 1;
            end
         end else if (pick == 9) begin
            col = rand_index();
            row = rand_index();
         end
         queue_request(ACT_READ, col, row, rand_coord(1'b0), rand_coord(1'b0));
      end else begin
         queue_request(ACT_UNDEFINED, rand_index(), rand_index(),
                       rand_coord(1'b0), rand_coord(1'b0));
      end
   endtask

   task automatic wait_for_idle();
      while (requests_pending.size() != 0 || req_valid || results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one grid size register, then read it back
   task automatic set_grid_register(input logic reg_idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_ADDR_W-1:0] addr;
      int setting, held;
      addr = CSR_ADDR_W'({reg_idx, 2'b00});
      setting = int'(value[CFG_BITS-1:0]);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (setting >= GRID_MIN) begin
         if (reg_idx == REG_GRID_COLUMNS && setting <= MAX_COLUMNS) grid_cols = setting;
         if (reg_idx == REG_GRID_ROWS && setting <= MAX_ROWS) grid_rows = setting;
      end
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      held = (reg_idx == REG_GRID_COLUMNS) ? grid_cols : grid_rows;
      if (prdata !== CSR_DATA_W'(held)) begin
         mismatches++;
         $display("%0t: register %0d expected %0d, got %0d", $time, reg_idx, held, prdata);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      point_request_type next_req;
      if (!reset && (!req_valid || req_taken)) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (requests_pending.size() > 0) begin
            next_req = requests_pending.pop_front();
            req_action <= next_req.action;
            req_col <= next_req.col;
            req_row <= next_req.row;
            req_point_x <= next_req.x;
            req_point_y <= next_req.y;
            req_valid <= 1'b1;
            req_gap = pick_gap(req_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_stall = pick_gap(rsp_calm);
      end
   end

   // ---------------------------------------------------------------
   // Monitor: predict on request beats, check on result beats
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      point_result_type due;
      point_request_type seen;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            seen.action = req_action;
            seen.col = req_col;
            seen.row = req_row;
            seen.x = req_point_x;
            seen.y = req_point_y;
            results_due.push_back(predict_point_result(seen));
         end
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               mismatches++;
               $display("%0t: result beat with none expected: x=%0d y=%0d index=%0d status=%0d",
                        $time, rsp_result_x, rsp_result_y, rsp_nearest_index, rsp_status);
            end else begin
               due = results_due.pop_front();
               check_field("result_x", due.x, rsp_result_x);
               check_field("result_y", due.y, rsp_result_y);
               check_field("nearest_index", COORD_BITS'(due.index),
                           COORD_BITS'(rsp_nearest_index));
               check_field("status", COORD_BITS'(due.status), COORD_BITS'(rsp_status));
            end
         end
         // watchdog on beats and register traffic
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("warp_grid_point_store_test failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin
      int phase, cols, rows, k, low;
      bit coarse;
      logic [CSR_DATA_W-1:0] upper;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // illegal sizes leave the reset size in place, then both shrink to the minimum
      set_grid_register(REG_GRID_COLUMNS, CSR_DATA_W'(1));
      set_grid_register(REG_GRID_ROWS, CSR_DATA_W'(33));
      set_grid_register(REG_GRID_COLUMNS, CSR_DATA_W'(GRID_MIN));
      set_grid_register(REG_GRID_ROWS, CSR_DATA_W'(GRID_MIN));

      // Directed: 2x2 grid with extreme corners and a duplicate point
      queue_request(ACT_WRITE, 0, 0, COORD_TOP, COORD_TOP);
      queue_request(ACT_WRITE, 1, 0, COORD_BOTTOM, COORD_BOTTOM);
      queue_request(ACT_WRITE, 0, 1, COORD_TOP, COORD_TOP);
      queue_request(ACT_WRITE, 1, 1, -18'sd5, 18'sd7);
      // writes outside the grid
      queue_request(ACT_WRITE, 2, 0, 18'sd1, 18'sd1);
      queue_request(ACT_WRITE, -1, 1, 18'sd1, 18'sd1);
      queue_request(ACT_WRITE, 0, -64, 18'sd1, 18'sd1);
      queue_request(ACT_WRITE, 63, 63, 18'sd1, 18'sd1);
      // nearest: tie between entries 0 and 2, extreme low, near the origin
      queue_request(ACT_NEAREST, 0, 0, COORD_TOP, COORD_TOP);
      queue_request(ACT_NEAREST, 0, 0, COORD_BOTTOM, COORD_BOTTOM);
      queue_request(ACT_NEAREST, 0, 0, 18'sd0, 18'sd0);
      // reads inside, mirrored past either column edge, the low row edge, the low and high corners, then out of range
      queue_request(ACT_READ, 0, 0, 18'sd0, 18'sd0);
      queue_request(ACT_READ, 1, 1, 18'sd0, 18'sd0);
      queue_request(ACT_READ, -1, 0, 18'sd0, 18'sd0);
      queue_request(ACT_READ, 2, 0, 18'sd0, 18'sd0);
      queue_request(ACT_READ, 0, -1, 18'sd0, 18'sd0);
      queue_request(ACT_READ, 2, 2, 18'sd0, 18'sd0);
      queue_request(ACT_READ, -1, -1, 18'sd0, 18'sd0);
      queue_request(ACT_READ, -2, 0, 18'sd0, 18'sd0);
      queue_request(ACT_READ, 3, 0, 18'sd0, 18'sd0);
      queue_request(ACT_READ, 0, 3, 18'sd0, 18'sd0);
      queue_request(ACT_READ, 0, -2, 18'sd0, 18'sd0);
      queue_request(ACT_READ, -64, 63, 18'sd0, 18'sd0);
      queue_request(ACT_UNDEFINED, 0, 0, 18'sd0, 18'sd0);

      // Random phases over a range of grid shapes
      phase = 0;
      while (items_queued < ITEM_TARGET) begin
         case (phase)
            0: begin
               cols = MAX_COLUMNS;
               rows = GRID_MIN;
            end
            1: begin
               cols = GRID_MIN;
               rows = MAX_ROWS;
            end
            2: begin
               cols = GRID_RESET;
               rows = GRID_RESET;
            end
            3: begin
               cols = MAX_COLUMNS;
               rows = 4;
            end
            default: begin
               cols = $urandom_range(2, 16);
               rows = $urandom_range(2, 64 / cols);
            end
         endcase
         wait_for_idle();
         upper = $urandom() & ~CSR_DATA_W'(6'h3F);
         if ($urandom_range(0, 1)) begin
            low = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(33, 63);
            set_grid_register($urandom_range(0, 1) ? REG_GRID_ROWS : REG_GRID_COLUMNS,
                              upper | CSR_DATA_W'(low));
         end
         // only the low six bits count, so junk above them is harmless
         set_grid_register(REG_GRID_COLUMNS,
                           ($urandom_range(0, 3) == 0) ? (upper | CSR_DATA_W'(cols))
                                                       : CSR_DATA_W'(cols));
         set_grid_register(REG_GRID_ROWS, CSR_DATA_W'(rows));
         coarse = ($urandom_range(0, 2) == 0);
         // every entry in use gets written before anything reads it
         for (k = 0; k < grid_cols * grid_rows; k++) begin
            if (!loaded[k]) begin
               queue_request(ACT_WRITE, k % grid_cols, k / grid_cols,
                             rand_coord(coarse), rand_coord(coarse));
            end
         end
         repeat ($urandom_range(40, 70)) queue_random_request(coarse);
         phase++;
      end

      wait_for_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && results_due.size() == 0) begin
         $display("warp_grid_point_store_test passed");
      end else begin
         $display("warp_grid_point_store_test failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/wgps_pkg.sv
rtl/core/wgps_ram.sv
rtl/core/warp_grid_point_store.sv
tb/warp_grid_point_store_test.sv
